/* rtl/sbm_pkg.sv */
`timescale 1ns / 1ps

package sbm_pkg;

    // Width of the blend mode code
    localparam int FUNC_BITS = 5;

    // Fractional bits of the soft light square root
    localparam int SQRT_FRAC = 8;

    // Blend mode codes; codes above vivid light act as normal
    localparam logic [FUNC_BITS-1:0] MODE_NORMAL       = 5'd0;
    localparam logic [FUNC_BITS-1:0] MODE_MULTIPLY     = 5'd1;
    localparam logic [FUNC_BITS-1:0] MODE_SCREEN       = 5'd2;
    localparam logic [FUNC_BITS-1:0] MODE_OVERLAY      = 5'd3;
    localparam logic [FUNC_BITS-1:0] MODE_SOFT_LIGHT   = 5'd4;
    localparam logic [FUNC_BITS-1:0] MODE_HARD_LIGHT   = 5'd5;
    localparam logic [FUNC_BITS-1:0] MODE_COLOR_DODGE  = 5'd6;
    localparam logic [FUNC_BITS-1:0] MODE_COLOR_BURN   = 5'd7;
    localparam logic [FUNC_BITS-1:0] MODE_DARKEN       = 5'd8;
    localparam logic [FUNC_BITS-1:0] MODE_LIGHTEN      = 5'd9;
    localparam logic [FUNC_BITS-1:0] MODE_DIFFERENCE   = 5'd10;
    localparam logic [FUNC_BITS-1:0] MODE_EXCLUSION    = 5'd11;
    localparam logic [FUNC_BITS-1:0] MODE_ADD          = 5'd12;
    localparam logic [FUNC_BITS-1:0] MODE_SUBTRACT     = 5'd13;
    localparam logic [FUNC_BITS-1:0] MODE_REFLECT      = 5'd14;
    localparam logic [FUNC_BITS-1:0] MODE_GLOW         = 5'd15;
    localparam logic [FUNC_BITS-1:0] MODE_PS_OVERLAY   = 5'd16;
    localparam logic [FUNC_BITS-1:0] MODE_LINEAR_DODGE = 5'd17;
    localparam logic [FUNC_BITS-1:0] MODE_LINEAR_BURN  = 5'd18;
    localparam logic [FUNC_BITS-1:0] MODE_PIN_LIGHT    = 5'd19;
    localparam logic [FUNC_BITS-1:0] MODE_VIVID_LIGHT  = 5'd20;

endpackage

/* rtl/sbm_sqrt.sv */
`timescale 1ns / 1ps

module sbm_sqrt #(
    parameter int W = 8
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [W-1:0]                   i_s,
    output logic [W+sbm_pkg::SQRT_FRAC-1:0] o_root
);

    localparam int RB = W + sbm_pkg::SQRT_FRAC;
    localparam int VW = 2 * RB + 1;
    localparam logic [W-1:0] M = {W{1'b1}};

    logic [VW-1:0] r_rem  [RB+1];
    logic [RB-1:0] r_root [RB+1];

    // Load the radicand s*M scaled by the fractional bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (VW'(i_s) * VW'(M)) << (2 * sbm_pkg::SQRT_FRAC);
            r_root[0] <= '0;
        end
    end

    // Resolve one root bit per stage, top bit first
    for (genvar j = 1; j <= RB; j++) begin : g_stage
        localparam int K = RB - j;
        logic [VW-1:0] trial;
        assign trial = (VW'(r_root[j-1]) << (K + 1)) + (VW'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[j-1] >= trial) begin
                    r_rem[j]  <= r_rem[j-1] - trial;
                    r_root[j] <= r_root[j-1] | (RB'(1) << K);
                end else begin
                    r_rem[j]  <= r_rem[j-1];
                    r_root[j] <= r_root[j-1];
                end
            end
        end
    end

    assign o_root = r_root[RB];

endmodule

/* rtl/sbm_div.sv */
`timescale 1ns / 1ps

module sbm_div #(
    parameter int N  = 35,
    parameter int D  = 25,
    parameter int Q  = 8,
    parameter int SW = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [N-1:0]  i_num,
    input  logic [D-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic [Q-1:0]  o_q,
    output logic [SW-1:0] o_side
);

    logic [N-1:0]  r_rem  [Q-1];
    logic [D-1:0]  r_den  [Q-1];
    logic [Q-1:0]  r_q    [Q];
    logic [SW-1:0] r_side [Q];

    // Restoring division, one quotient bit per stage, top bit first
    for (genvar j = 0; j < Q; j++) begin : g_stage
        localparam int B = Q - 1 - j;
        logic [N-1:0]  src_rem;
        logic [D-1:0]  src_den;
        logic [Q-1:0]  src_q;
        logic [SW-1:0] src_side;
        logic [N-1:0]  trial;
        logic          hit;

        if (j == 0) begin : g_first
            assign src_rem  = i_num;
            assign src_den  = i_den;
            assign src_q    = '0;
            assign src_side = i_side;
        end else begin : g_next
            assign src_rem  = r_rem[j-1];
            assign src_den  = r_den[j-1];
            assign src_q    = r_q[j-1];
            assign src_side = r_side[j-1];
        end

        assign trial = N'(src_den) << B;
        assign hit   = (src_rem >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]    <= hit ? (src_q | (Q'(1) << B)) : src_q;
                r_side[j] <= src_side;
            end
        end

        if (j < Q - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= hit ? (src_rem - trial) : src_rem;
                    r_den[j] <= src_den;
                end
            end
        end
    end

    assign o_q    = r_q[Q-1];
    assign o_side = r_side[Q-1];

endmodule

/* rtl/sbm_lane.sv */
`timescale 1ns / 1ps

module sbm_lane #(
    parameter int W          = 8,
    parameter bit ALPHA_LANE = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sbm_pkg::FUNC_BITS-1:0] i_func,
    input  logic [W-1:0]                  i_s,
    input  logic [W-1:0]                  i_d,
    input  logic [W-1:0]                  i_as,
    input  logic [W-1:0]                  i_ad,
    output logic [W-1:0]                  o_res
);

    localparam int RB  = W + sbm_pkg::SQRT_FRAC;
    localparam int DLY = RB + 1;
    localparam int NW  = 3 * W + 10;
    localparam int DW  = 2 * W + 8;
    localparam int N   = NW + 1;
    localparam int DN  = DW + 1;
    localparam logic [W-1:0] M = {W{1'b1}};

    typedef logic signed [NW-1:0] t_num;

    typedef struct packed {
        logic [sbm_pkg::FUNC_BITS-1:0] func;
        logic [W-1:0]   s;
        logic [W-1:0]   d;
        logic [W-1:0]   a_s;
        logic [2*W-1:0] sd;
        logic [2*W-1:0] ss;
        logic [2*W-1:0] sa;
        logic [2*W-1:0] da;
        logic [2*W-1:0] dd;
        logic [2*W-1:0] msmd;
        logic [2*W-1:0] smd;
        logic [2*W-1:0] aa;
    } t_pl;

    function automatic logic [2*W-1:0] umul(input logic [W-1:0] a, input logic [W-1:0] b);
        return (2 * W)'(a) * (2 * W)'(b);
    endfunction

    t_pl           n_pl;
    t_pl           r_pl [DLY];
    logic [RB-1:0] root;

    // Form the first products of the channel pair
    always_comb begin
        n_pl.func = i_func;
        n_pl.s    = i_s;
        n_pl.d    = i_d;
        n_pl.a_s  = i_as;
        n_pl.sd   = umul(i_s, i_d);
        n_pl.ss   = umul(i_s, i_s);
        n_pl.sa   = umul(i_s, i_as);
        n_pl.da   = umul(i_d, i_ad);
        n_pl.dd   = umul(i_d, i_d);
        n_pl.msmd = umul(M - i_s, M - i_d);
        n_pl.smd  = umul(i_s, M - i_d);
        n_pl.aa   = umul(i_ad, M - i_as);
    end

    // Hold the products alongside the square root pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl[0] <= n_pl;
            for (int k = 1; k < DLY; k++) begin
                r_pl[k] <= r_pl[k-1];
            end
        end
    end

    sbm_sqrt #(.W(W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_s    (i_s),
        .o_root (root)
    );

    // Select numerator and denominator of the mode, or a bypass value
    t_num          n_num, r_num;
    logic [DW-1:0] n_den, r_den;
    logic          n_byp, r_fbyp;
    logic [W-1:0]  n_val, r_fval;

    always_comb begin
        t_num s, d, a_s, sd, ss, sa, da, dd, msmd, smd, aa, rt;
        t_num cm, mm, aon, m_ss, m_rt, m_da, tmp;
        logic lo_d, lo_s, is_normal;
        t_pl  pl;

        pl   = r_pl[DLY-1];
        cm   = t_num'(M);
        s    = t_num'(pl.s);
        d    = t_num'(pl.d);
        a_s  = t_num'(pl.a_s);
        sd   = t_num'(pl.sd);
        ss   = t_num'(pl.ss);
        sa   = t_num'(pl.sa);
        da   = t_num'(pl.da);
        dd   = t_num'(pl.dd);
        msmd = t_num'(pl.msmd);
        smd  = t_num'(pl.smd);
        aa   = t_num'(pl.aa);
        rt   = t_num'(root);
        mm   = cm * cm;
        m_ss = ss * (cm - (d <<< 1));
        m_rt = rt * ((d <<< 1) - cm);
        m_da = da * (cm - a_s);
        aon  = a_s * cm + aa;
        lo_d = ((d <<< 1) < cm);
        lo_s = ((s <<< 1) < cm);
        tmp  = '0;
        is_normal = (pl.func == sbm_pkg::MODE_NORMAL) ||
                    (pl.func > sbm_pkg::MODE_VIVID_LIGHT);

        n_num = '0;
        n_den = '0;
        n_byp = 1'b1;
        n_val = '0;

        if (ALPHA_LANE) begin
            if (is_normal) begin
                n_byp = 1'b0;
                n_num = aon;
                n_den = DW'(M);
            end else begin
                n_val = pl.s;
            end
        end else if (is_normal) begin
            if (aon != '0) begin
                n_byp = 1'b0;
                n_num = sa * cm + m_da;
                n_den = DW'(aon);
            end
        end else begin
            case (pl.func)
                sbm_pkg::MODE_MULTIPLY: begin
                    n_byp = 1'b0;
                    n_num = sd;
                    n_den = DW'(M);
                end
                sbm_pkg::MODE_SCREEN: begin
                    n_byp = 1'b0;
                    n_num = mm - msmd;
                    n_den = DW'(M);
                end
                sbm_pkg::MODE_OVERLAY, sbm_pkg::MODE_PS_OVERLAY: begin
                    n_byp = 1'b0;
                    n_num = lo_d ? (sd <<< 1) : (mm - (msmd <<< 1));
                    n_den = DW'(M);
                end
                sbm_pkg::MODE_HARD_LIGHT: begin
                    n_byp = 1'b0;
                    n_num = lo_s ? (sd <<< 1) : (mm - (msmd <<< 1));
                    n_den = DW'(M);
                end
                sbm_pkg::MODE_SOFT_LIGHT: begin
                    n_byp = 1'b0;
                    if (lo_d) begin
                        n_num = ((sd * cm) <<< 1) + m_ss;
                        n_den = DW'(mm);
                    end else begin
                        n_num = m_rt + (smd <<< 9);
                        n_den = DW'(cm <<< sbm_pkg::SQRT_FRAC);
                    end
                end
                sbm_pkg::MODE_COLOR_DODGE: begin
                    if (d < cm) begin
                        n_byp = 1'b0;
                        n_num = s * cm;
                        n_den = DW'(cm - d);
                    end else begin
                        n_val = M;
                    end
                end
                sbm_pkg::MODE_COLOR_BURN: begin
                    if (d > '0) begin
                        n_byp = 1'b0;
                        n_num = cm * (d + s - cm);
                        n_den = DW'(d);
                    end
                end
                sbm_pkg::MODE_DARKEN: begin
                    n_val = (s < d) ? pl.s : pl.d;
                end
                sbm_pkg::MODE_LIGHTEN: begin
                    n_val = (s > d) ? pl.s : pl.d;
                end
                sbm_pkg::MODE_DIFFERENCE: begin
                    n_val = (s > d) ? W'(s - d) : W'(d - s);
                end
                sbm_pkg::MODE_EXCLUSION: begin
                    n_byp = 1'b0;
                    n_num = (s + d) * cm - (sd <<< 1);
                    n_den = DW'(M);
                end
                sbm_pkg::MODE_ADD, sbm_pkg::MODE_LINEAR_DODGE: begin
                    tmp   = s + d;
                    n_val = (tmp > cm) ? M : W'(tmp);
                end
                sbm_pkg::MODE_SUBTRACT: begin
                    n_val = (s < d) ? '0 : W'(s - d);
                end
                sbm_pkg::MODE_LINEAR_BURN: begin
                    tmp   = s + d - cm;
                    n_val = (tmp < 0) ? '0 : W'(tmp);
                end
                sbm_pkg::MODE_REFLECT: begin
                    if (s == cm) begin
                        n_val = M;
                    end else begin
                        n_byp = 1'b0;
                        n_num = dd;
                        n_den = DW'(cm - s);
                    end
                end
                sbm_pkg::MODE_GLOW: begin
                    if (s != '0) begin
                        n_byp = 1'b0;
                        n_num = cm * (s + d - cm);
                        n_den = DW'(s);
                    end
                end
                sbm_pkg::MODE_PIN_LIGHT: begin
                    if (lo_d) begin
                        n_val = ((s <<< 1) < d) ? W'(s <<< 1) : pl.d;
                    end else begin
                        tmp   = (s <<< 1) - cm;
                        n_val = (tmp > d) ? W'(tmp) : pl.d;
                    end
                end
                sbm_pkg::MODE_VIVID_LIGHT: begin
                    if (lo_d) begin
                        if (d != '0) begin
                            n_byp = 1'b0;
                            n_num = cm * ((d <<< 1) + s - cm);
                            n_den = DW'(d <<< 1);
                        end
                    end else if (d == cm) begin
                        n_val = M;
                    end else begin
                        n_byp = 1'b0;
                        n_num = s * cm;
                        n_den = DW'((cm - d) <<< 1);
                    end
                end
                default: begin
                    n_val = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_fbyp <= n_byp;
            r_fval <= n_val;
        end
    end

    // Prepare the rounded division and catch bypass, non-positive and saturated results
    logic [N-1:0]  n_n2, r_n2;
    logic [DN-1:0] n_d2, r_d2;
    logic [W:0]    n_side, r_side;
    logic          sat;

    always_comb begin
        n_n2 = (N'(r_num) << 1) + N'(r_den);
        n_d2 = {r_den, 1'b0};
        sat  = (n_n2 >= (N'(n_d2) << W));
        if (r_fbyp) begin
            n_side = {1'b1, r_fval};
        end else if (r_num <= t_num'(0)) begin
            n_side = {1'b1, {W{1'b0}}};
        end else if (sat) begin
            n_side = {1'b1, M};
        end else begin
            n_side = {1'b0, {W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n2   <= n_n2;
            r_d2   <= n_d2;
            r_side <= n_side;
        end
    end

    logic [W-1:0] q;
    logic [W:0]   side;

    sbm_div #(.N(N), .D(DN), .Q(W), .SW(W + 1)) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_n2),
        .i_den  (r_d2),
        .i_side (r_side),
        .o_q    (q),
        .o_side (side)
    );

    assign o_res = side[W] ? side[W-1:0] : q;

endmodule

/* rtl/separable_blend_mode_unit.sv */
`timescale 1ns / 1ps
// Pipeline: each lane holds the CHANNEL_BITS+8 square root stages and the CHANNEL_BITS
// divider stages, between the input capture register and the output register.
// Throughput: one pixel per cycle while o_stall is low; a two-entry output register and skid part the sides.
// Reset: synchronous, active low; clears all valid flags, payload registers are not reset.

module separable_blend_mode_unit #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sbm_pkg::FUNC_BITS-1:0] i_func,
    input  logic [CHANNEL_BITS-1:0]       i_src_r,
    input  logic [CHANNEL_BITS-1:0]       i_src_g,
    input  logic [CHANNEL_BITS-1:0]       i_src_b,
    input  logic [CHANNEL_BITS-1:0]       i_src_a,
    input  logic [CHANNEL_BITS-1:0]       i_dst_r,
    input  logic [CHANNEL_BITS-1:0]       i_dst_g,
    input  logic [CHANNEL_BITS-1:0]       i_dst_b,
    input  logic [CHANNEL_BITS-1:0]       i_dst_a,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [CHANNEL_BITS-1:0]       o_out_r,
    output logic [CHANNEL_BITS-1:0]       o_out_g,
    output logic [CHANNEL_BITS-1:0]       o_out_b,
    output logic [CHANNEL_BITS-1:0]       o_out_a
);

    localparam int W     = CHANNEL_BITS;
    localparam int DEPTH = 2 * W + 11;

    logic                          en, accept, p_valid, out_free;
    logic                          r_in_valid, r_out_valid, r_skid_valid;
    logic [DEPTH-1:0]              r_vld;
    logic [sbm_pkg::FUNC_BITS-1:0] r_func;
    logic [W-1:0]                  r_src [4];
    logic [W-1:0]                  r_dst [4];
    logic [W-1:0]                  l_res [4];
    logic [W-1:0]                  r_out [4];
    logic [W-1:0]                  r_skid [4];

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_src[0] <= i_src_r;
            r_src[1] <= i_src_g;
            r_src[2] <= i_src_b;
            r_src[3] <= i_src_a;
            r_dst[0] <= i_dst_r;
            r_dst[1] <= i_dst_g;
            r_dst[2] <= i_dst_b;
            r_dst[3] <= i_dst_a;
        end
    end

    // Advance the valid flags with the lane pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], r_in_valid};
        end
    end

    // Three color lanes and one alpha lane
    for (genvar i = 0; i < 4; i++) begin : g_lane
        sbm_lane #(.W(W), .ALPHA_LANE(i == 3)) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_func (r_func),
            .i_s    (r_src[i]),
            .i_d    (r_dst[i]),
            .i_as   (r_src[3]),
            .i_ad   (r_dst[3]),
            .o_res  (l_res[i])
        );
    end

    // Merge the lane results into the output register, spill to skid on stall
    assign p_valid  = r_vld[DEPTH-1];
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= p_valid;
            end
        end else if (p_valid && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : l_res;
        end else if (p_valid && en) begin
            r_skid <= l_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out_r = r_out[0];
    assign o_out_g = r_out[1];
    assign o_out_b = r_out[2];
    assign o_out_a = r_out[3];

endmodule
